[hdl/round_robin_task_scheduler_macros.svh]
// Assertion macros used by the round-robin task scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RRTS_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rrts: same-cycle check failed");
`define RRTS_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rrts: next-cycle check failed");
`else
`define RRTS_ASSERT_IMP(label, ck, rn, ante, cons)
`define RRTS_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

[hdl/rrts_pkg.sv]
// Types and constants of the round-robin task scheduler.
`default_nettype none
package rrts_pkg;

  localparam int GEN_W      = 32;
  localparam int ID_W       = 64;
  localparam int SLICE_W    = 16;
  localparam int BASE_W     = 32;
  localparam int SIZE_W     = 21;
  localparam int CFG_W      = 32;
  localparam int USE_OUT_W  = 7;

  localparam logic [GEN_W-1:0] GEN_MAX       = 32'hFFFF_FFFF;
  localparam logic [GEN_W-1:0] GEN_BOOT      = 32'd1;
  localparam logic [GEN_W-1:0] GEN_FIRST     = 32'd2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd5;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 32'd0;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 21'd8192;

  localparam logic [1:0] CMD_CREATE   = 2'd0;
  localparam logic [1:0] CMD_FREE     = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_SCHEDULE = 2'd3;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_REFUSED  = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  localparam logic [1:0] CFG_TIME_SLICE = 2'd0;
  localparam logic [1:0] CFG_STACK_BASE = 2'd1;
  localparam logic [1:0] CFG_STACK_SIZE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_SCHED_RD,
    ST_SCHED_G1,
    ST_SCHED_G2,
    ST_ADDR,
    ST_DONE
  } sched_state_t;

  typedef struct packed {
    logic            done;
    logic [ID_W-1:0] addr;
  } stk_stat_t;

endpackage
`default_nettype wire

[hdl/rrts_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/rrts_stack_unit.sv]
// Two-stage stack address unit: multiply slot by stack size, then add the base.
`default_nettype none
module rrts_stack_unit
  import rrts_pkg::*;
#(
  parameter int SW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SW-1:0]     slot,
  input  wire logic [BASE_W-1:0] base,
  input  wire logic [SIZE_W-1:0] size,
  output stk_stat_t              stat
);

  localparam int PW = SIZE_W + SW;

  logic          prod_vld_r;
  logic          done_r;
  logic [PW-1:0] prod_r;
  logic [ID_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      prod_vld_r <= start;
      done_r     <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PW'(size) * PW'(slot);
    end
    if (prod_vld_r) begin
      addr_r <= ID_W'(base) + ID_W'(prod_r);
    end
  end

  assign stat.done = done_r;
  assign stat.addr = addr_r;

endmodule
`default_nettype wire

[hdl/round_robin_task_scheduler.sv]
// Round-robin task scheduler: slot pool, ready queue, time slice and control sequencer.
`default_nettype none
`include "round_robin_task_scheduler_macros.svh"
// After reset the block clears the generation memory (slot 0 is the boot
// task) and takes no word until that is done. Each word then runs alone
// through a small sequencer built around the generation memory's single read
// port: a tick, or a refused create or switch, goes straight to the result, a
// free reads the slot's generation first (unless the index lies past the pool),
// a switch reads the queue, then makes two generation reads, and a create finds
// the lowest free slot by reading the generation memory one entry per cycle,
// then waits for the stack address. The result sits in an output register, so
// the next word is taken while it waits.
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [ID_W-1:0]   in_task_id,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [ID_W-1:0]        out_result_id,
  output logic [ID_W-1:0]        out_previous_id,
  output logic [ID_W-1:0]        out_stack_address,
  output logic                   out_slice_expired,
  output logic [USE_OUT_W-1:0]   out_slots_in_use,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = CW + 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  sched_state_t state_r, state_nxt;

  logic [SLICE_W-1:0] time_slice_r;
  logic [BASE_W-1:0]  stack_base_r;
  logic [SIZE_W-1:0]  stack_size_r;

  logic [GEN_W-1:0]   next_gen_r, next_gen_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [SW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      rcount_r, rcount_nxt;
  logic [SW-1:0]      running_r, running_nxt;
  logic [SLICE_W-1:0] slice_r, slice_nxt;
  logic [SW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [SW-1:0]      scan_idx_r, scan_idx_nxt;
  logic [SW-1:0]      chk_idx_r, chk_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working result and operands, no reset needed.
  logic [SW-1:0]      free_idx_r, free_idx_nxt;
  logic [SW-1:0]      prev_slot_r, prev_slot_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [ID_W-1:0]    res_rid_r, res_rid_nxt;
  logic [ID_W-1:0]    res_pid_r, res_pid_nxt;
  logic [ID_W-1:0]    res_addr_r, res_addr_nxt;
  logic               out_load;
  logic [1:0]         out_status_r;
  logic [ID_W-1:0]    out_rid_r, out_pid_r, out_addr_r;
  logic               out_exp_r;
  logic [USE_OUT_W-1:0] out_use_r;

  logic               gen_we;
  logic [SW-1:0]      gen_waddr, gen_raddr;
  logic [GEN_W-1:0]   gen_wdata, gen_rdata;
  logic               fifo_we;
  logic [SW-1:0]      fifo_wdata, fifo_rdata;

  logic [TW-1:0]      tail_sum;
  logic [SW-1:0]      tail_idx;

  logic               stk_start;
  stk_stat_t          stk_stat;

  rrts_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  rrts_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail_idx),
    .wdata (fifo_wdata),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  rrts_stack_unit #(.SW(SW)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .start (stk_start),
    .slot  (chk_idx_r),
    .base  (stack_base_r),
    .size  (stack_size_r),
    .stat  (stk_stat)
  );

  // Queue tail is (head + count) mod SLOTS; the sum stays below twice SLOTS.
  assign tail_sum = TW'(head_r) + TW'(rcount_r);
  assign tail_idx = (tail_sum >= TW'(SLOTS)) ? SW'(tail_sum - TW'(SLOTS)) : SW'(tail_sum);

  always_comb begin
    case (state_r)
      ST_IDLE:     gen_raddr = in_task_id[SW-1:0];
      ST_SCAN:     gen_raddr = scan_idx_r;
      ST_SCHED_RD: gen_raddr = fifo_rdata;
      ST_SCHED_G1: gen_raddr = prev_slot_r;
      default:     gen_raddr = scan_idx_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    next_gen_nxt   = next_gen_r;
    used_nxt       = used_r;
    head_nxt       = head_r;
    rcount_nxt     = rcount_r;
    running_nxt    = running_r;
    slice_nxt      = slice_r;
    clr_idx_nxt    = clr_idx_r;
    scan_idx_nxt   = scan_idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    free_idx_nxt   = free_idx_r;
    prev_slot_nxt  = prev_slot_r;
    res_status_nxt = res_status_r;
    res_rid_nxt    = res_rid_r;
    res_pid_nxt    = res_pid_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_load       = 1'b0;
    gen_we         = 1'b0;
    gen_waddr      = chk_idx_r;
    gen_wdata      = next_gen_r;
    fifo_we        = 1'b0;
    fifo_wdata     = chk_idx_r;
    stk_start      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        gen_we    = 1'b1;
        gen_waddr = clr_idx_r;
        gen_wdata = (clr_idx_r == '0) ? GEN_BOOT : '0;
        if (clr_idx_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_status_nxt = STATUS_DONE;
          res_rid_nxt    = '0;
          res_pid_nxt    = '0;
          res_addr_nxt   = '0;
          free_idx_nxt   = in_task_id[SW-1:0];
          case (in_cmd)
            CMD_CREATE: begin
              if (used_r < CW'(SLOTS)) begin
                scan_idx_nxt = '0;
                chk_vld_nxt  = 1'b0;
                state_nxt    = ST_SCAN;
              end else begin
                res_status_nxt = STATUS_REFUSED;
                state_nxt      = ST_DONE;
              end
            end
            CMD_FREE: begin
              // Only the low half of the id names the slot.
              if (in_task_id[GEN_W-1:0] >= GEN_W'(SLOTS)) begin
                res_status_nxt = STATUS_BAD_FREE;
                state_nxt      = ST_DONE;
              end else begin
                state_nxt = ST_FREE_RD;
              end
            end
            CMD_TICK: begin
              if (slice_r != '0) begin
                slice_nxt = slice_r - 1'b1;
              end
              state_nxt = ST_DONE;
            end
            CMD_SCHEDULE: begin
              if (rcount_r == '0) begin
                res_status_nxt = STATUS_REFUSED;
                state_nxt      = ST_DONE;
              end else begin
                state_nxt = ST_SCHED_RD;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        // Read data arrives in the cycle after its address; chk_idx_r tracks it.
        if (chk_vld_r && gen_rdata == '0) begin
          gen_we       = 1'b1;
          next_gen_nxt = (next_gen_r == GEN_MAX) ? GEN_BOOT : next_gen_r + 1'b1;
          used_nxt     = used_r + 1'b1;
          res_rid_nxt  = {next_gen_r, GEN_W'(chk_idx_r)};
          if (rcount_r < CW'(SLOTS)) begin
            fifo_we    = 1'b1;
            rcount_nxt = rcount_r + 1'b1;
          end
          stk_start = 1'b1;
          state_nxt = ST_ADDR;
        end else if (chk_vld_r && chk_idx_r == LAST_SLOT) begin
          res_status_nxt = STATUS_REFUSED;
          state_nxt      = ST_DONE;
        end else begin
          chk_idx_nxt = scan_idx_r;
          chk_vld_nxt = 1'b1;
          if (scan_idx_r != LAST_SLOT) begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
      end
      ST_FREE_RD: begin
        if (gen_rdata == '0) begin
          res_status_nxt = STATUS_BAD_FREE;
        end else begin
          gen_we    = 1'b1;
          gen_waddr = free_idx_r;
          gen_wdata = '0;
          if (used_r != '0) begin
            used_nxt = used_r - 1'b1;
          end
        end
        state_nxt = ST_DONE;
      end
      ST_SCHED_RD: begin
        // Pop the head and push the running slot: the count does not change.
        fifo_we       = 1'b1;
        fifo_wdata    = running_r;
        prev_slot_nxt = running_r;
        running_nxt   = fifo_rdata;
        head_nxt      = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
        slice_nxt     = time_slice_r;
        state_nxt     = ST_SCHED_G1;
      end
      ST_SCHED_G1: begin
        res_rid_nxt = {gen_rdata, GEN_W'(running_r)};
        state_nxt   = ST_SCHED_G2;
      end
      ST_SCHED_G2: begin
        res_pid_nxt = {gen_rdata, GEN_W'(prev_slot_r)};
        state_nxt   = ST_DONE;
      end
      ST_ADDR: begin
        if (stk_stat.done) begin
          res_addr_nxt = stk_stat.addr;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      next_gen_r  <= GEN_FIRST;
      used_r      <= CW'(1);
      head_r      <= '0;
      rcount_r    <= '0;
      running_r   <= '0;
      slice_r     <= '0;
      clr_idx_r   <= '0;
      scan_idx_r  <= '0;
      chk_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_gen_r  <= next_gen_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      rcount_r    <= rcount_nxt;
      running_r   <= running_nxt;
      slice_r     <= slice_nxt;
      clr_idx_r   <= clr_idx_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_slice_r <= SLICE_RESET;
      stack_base_r <= BASE_RESET;
      stack_size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_SLICE: time_slice_r <= cfg_wdata[SLICE_W-1:0];
        CFG_STACK_BASE: stack_base_r <= cfg_wdata[BASE_W-1:0];
        CFG_STACK_SIZE: stack_size_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    free_idx_r   <= free_idx_nxt;
    prev_slot_r  <= prev_slot_nxt;
    res_status_r <= res_status_nxt;
    res_rid_r    <= res_rid_nxt;
    res_pid_r    <= res_pid_nxt;
    res_addr_r   <= res_addr_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_rid_r    <= res_rid_r;
      out_pid_r    <= res_pid_r;
      out_addr_r   <= res_addr_r;
      out_exp_r    <= (slice_r == '0);
      out_use_r    <= USE_OUT_W'(used_r);
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_rid_r;
  assign out_previous_id   = out_pid_r;
  assign out_stack_address = out_addr_r;
  assign out_slice_expired = out_exp_r;
  assign out_slots_in_use  = out_use_r;

  `RRTS_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != ST_IDLE)
  `RRTS_ASSERT_IMP(a_gen_nonzero, clk, rst_n, 1'b1, next_gen_r != '0)
  `RRTS_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, rcount_r <= CW'(SLOTS))
  `RRTS_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= CW'(SLOTS))
  `RRTS_ASSERT_IMP(a_stack_in_addr, clk, rst_n, stk_stat.done, state_r == ST_ADDR)

endmodule
`default_nettype wire

[verif/round_robin_task_scheduler_test.sv]
// Self-checking testbench for the round-robin task scheduler: directed cases and random traffic.
`timescale 1ns / 100ps

module round_robin_task_scheduler_test
  import rrts_pkg::*;
();

  localparam int SLOTS      = 64;
  localparam int HANG_LIMIT = 1000;
  localparam int TAIL_WAIT  = SLOTS + 8;

  typedef struct {
    logic [1:0]           status;
    logic [ID_W-1:0]      result_id;
    logic [ID_W-1:0]      previous_id;
    logic [ID_W-1:0]      stack_address;
    logic                 slice_expired;
    logic [USE_OUT_W-1:0] slots_in_use;
  } outcome_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_cmd;
  logic [ID_W-1:0]      in_task_id;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_status;
  logic [ID_W-1:0]      out_result_id;
  logic [ID_W-1:0]      out_previous_id;
  logic [ID_W-1:0]      out_stack_address;
  logic                 out_slice_expired;
  logic [USE_OUT_W-1:0] out_slots_in_use;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Shadow copy of the scheduler state.
  logic [GEN_W-1:0]   slot_gen [SLOTS];
  logic [GEN_W-1:0]   gen_next;
  int                 slots_used;
  int                 ready_ring [SLOTS];
  int                 ring_head;
  int                 ring_len;
  int                 run_slot;
  int                 slice_count;
  logic [SLICE_W-1:0] cfg_slice;
  logic [BASE_W-1:0]  cfg_base;
  logic [SIZE_W-1:0]  cfg_size;

  outcome_t expected_outcomes [$];

  int  error_count = 0;
  int  cmd_count [4] = '{default: 0};
  int  status_count [4] = '{default: 0};
  int  pool_full_hits = 0;
  int  ring_drops = 0;
  bit  no_idle = 1'b0;
  bit  valid_held = 1'b0;
  int  next_gap = 0;

  round_robin_task_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_task_id        (in_task_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_result_id     (out_result_id),
    .out_previous_id   (out_previous_id),
    .out_stack_address (out_stack_address),
    .out_slice_expired (out_slice_expired),
    .out_slots_in_use  (out_slots_in_use),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [ID_W-1:0] task_id_of(input int slot);
    return {slot_gen[slot], 32'(slot)};
  endfunction

  function automatic void ring_append(input int slot);
    if (ring_len >= SLOTS) begin
      ring_drops++;
      return;
    end
    ready_ring[(ring_head + ring_len) % SLOTS] = slot;
    ring_len++;
  endfunction

  // Applies one accepted word to the shadow state and queues the result it must produce.
  function automatic void predict_outcome(input logic [1:0] cmd, input logic [ID_W-1:0] tid);
    outcome_t o;
    int slot;
    int nxt;
    int prv;
    o = '{status: STATUS_DONE, result_id: '0, previous_id: '0, stack_address: '0,
          slice_expired: 1'b0, slots_in_use: '0};
    case (cmd)
      CMD_CREATE: begin
        slot = SLOTS;
        if (slots_used < SLOTS) begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (slot_gen[i] == '0) slot = i;
        end
        if (slot >= SLOTS) begin
          o.status = STATUS_REFUSED;
          pool_full_hits++;
        end else begin
          slot_gen[slot] = gen_next;
          gen_next = (gen_next == GEN_MAX) ? 32'd1 : gen_next + 32'd1;
          slots_used++;
          o.result_id = task_id_of(slot);
          o.stack_address = 64'(cfg_base) + 64'(cfg_size) * 64'(slot);
          ring_append(slot);
        end
      end
      CMD_FREE: begin
        if (tid[31:0] >= 32'(SLOTS) || slot_gen[tid[31:0]] == '0) begin
          o.status = STATUS_BAD_FREE;
        end else begin
          slot_gen[tid[31:0]] = '0;
          if (slots_used > 0) slots_used--;
        end
      end
      CMD_TICK: begin
        if (slice_count > 0) slice_count--;
      end
      default: begin
        if (ring_len == 0) begin
          o.status = STATUS_REFUSED;
        end else begin
          nxt = ready_ring[ring_head];
          prv = run_slot;
          ring_head = (ring_head + 1) % SLOTS;
          ring_len--;
          ring_append(prv);
          run_slot = nxt;
          slice_count = int'(cfg_slice);
          o.result_id = task_id_of(nxt);
          o.previous_id = task_id_of(prv);
        end
      end
    endcase
    o.slice_expired = (slice_count == 0);
    o.slots_in_use = USE_OUT_W'(slots_used);
    expected_outcomes.push_back(o);
  endfunction

  // Mostly ids of live slots, some ids of random slots and some with wild indexes.
  function automatic logic [ID_W-1:0] pick_free_target();
    int kind;
    int start;
    logic [31:0] idx;
    kind = $urandom_range(0, 9);
    start = $urandom_range(0, SLOTS - 1);
    idx = 32'(start);
    if (kind < 7) begin
      for (int k = SLOTS - 1; k >= 0; k--)
        if (slot_gen[(start + k) % SLOTS] != '0) idx = 32'((start + k) % SLOTS);
    end else if (kind == 9) begin
      idx = $urandom();
    end
    return {32'($urandom()), idx};
  endfunction

  // Sends one word. Valid stays up into the next word when the next gap is zero, so it is
  // never lowered and raised in the same step.
  task automatic send_word(input logic [1:0] cmd, input logic [ID_W-1:0] tid);
    if (!valid_held) repeat (next_gap) @(posedge clk);
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_task_id <= tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_outcome(cmd, tid);
    cmd_count[cmd]++;
    next_gap = no_idle ? 0 : $urandom_range(0, 3);
    valid_held = (next_gap == 0);
    if (!valid_held) in_valid <= 1'b0;
  endtask

  task automatic stop_sending();
    if (valid_held) in_valid <= 1'b0;
    valid_held = 1'b0;
    next_gap = 1;
  endtask

  task automatic drain_and_settle();
    stop_sending();
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_TIME_SLICE: cfg_slice = data[SLICE_W-1:0];
      CFG_STACK_BASE: cfg_base  = data[BASE_W-1:0];
      CFG_STACK_SIZE: cfg_size  = data[SIZE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reprogram(input logic [SLICE_W-1:0] slice, input logic [BASE_W-1:0] base,
                           input logic [SIZE_W-1:0] size);
    drain_and_settle();
    write_reg(CFG_TIME_SLICE, CFG_W'(slice));
    write_reg(CFG_STACK_BASE, CFG_W'(base));
    write_reg(CFG_STACK_SIZE, CFG_W'(size));
  endtask

  task automatic test_reset_defaults();
    for (int s = 0; s < SLOTS; s++) begin
      slot_gen[s] = '0;
      ready_ring[s] = 0;
    end
    slot_gen[0] = GEN_BOOT;
    gen_next    = GEN_FIRST;
    slots_used  = 1;
    ring_head   = 0;
    ring_len    = 0;
    run_slot    = 0;
    slice_count = 0;
    cfg_slice   = SLICE_RESET;
    cfg_base    = BASE_RESET;
    cfg_size    = SIZE_RESET;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_word(CMD_TICK, '0);
    send_word(CMD_SCHEDULE, '1);
    send_word(CMD_FREE, 64'hFFFF_FFFF_0000_0040);
    send_word(CMD_FREE, '1);
    send_word(CMD_FREE, 64'd1);
  endtask

  task automatic test_create_free_switch();
    send_word(CMD_CREATE, '0);
    send_word(CMD_CREATE, '1);
    send_word(CMD_SCHEDULE, '0);
    send_word(CMD_TICK, '1);
    // The upper half of the id is not compared, so this frees slot 2 while it is queued.
    send_word(CMD_FREE, {32'hA5A5_5A5A, 32'd2});
    send_word(CMD_SCHEDULE, '0);
    send_word(CMD_FREE, 64'd0);
    send_word(CMD_SCHEDULE, '0);
    send_word(CMD_CREATE, '0);
    send_word(CMD_FREE, 64'd2);
  endtask

  task automatic test_slice_settings();
    reprogram(16'd0, 32'h0000_1000, 21'd0);
    send_word(CMD_CREATE, '0);
    send_word(CMD_SCHEDULE, '0);
    send_word(CMD_TICK, '0);
    reprogram(16'd1, 32'h8000_0000, 21'd1);
    send_word(CMD_SCHEDULE, '0);
    send_word(CMD_TICK, '0);
    send_word(CMD_TICK, '0);
    reprogram(16'hFFFF, 32'h7FFF_FFFF, 21'h1F_FFFF);
    send_word(CMD_SCHEDULE, '0);
    send_word(CMD_TICK, '0);
  endtask

  // Fills the pool, then recycles queued slots until the ready queue overflows.
  task automatic test_pool_exhaustion();
    reprogram(16'd3, 32'hFFFF_FFFF, 21'd1048576);
    while (slots_used < SLOTS) begin
      if ($urandom_range(0, 3) == 0) send_word(CMD_TICK, {$urandom(), $urandom()});
      send_word(CMD_CREATE, {$urandom(), $urandom()});
    end
    send_word(CMD_CREATE, '0);
    for (int n = 0; n < 6; n++) begin
      send_word(CMD_FREE, {32'($urandom()), 32'($urandom_range(1, SLOTS - 1))});
      send_word(CMD_CREATE, '0);
    end
    repeat (4) send_word(CMD_SCHEDULE, '0);
  endtask

  task automatic test_random_traffic(input int words, input int pct_create, input int pct_free,
                                     input int pct_tick);
    int r;
    for (int n = 0; n < words; n++) begin
      r = $urandom_range(0, 99);
      if (r < pct_create)
        send_word(CMD_CREATE, {$urandom(), $urandom()});
      else if (r < pct_create + pct_free)
        send_word(CMD_FREE, pick_free_target());
      else if (r < pct_create + pct_free + pct_tick)
        send_word(CMD_TICK, {$urandom(), $urandom()});
      else
        send_word(CMD_SCHEDULE, {$urandom(), $urandom()});
    end
  endtask

  function automatic void check_field(input string name, input logic [ID_W-1:0] want,
                                      input logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  initial begin : result_check
    int stall;
    outcome_t want;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      status_count[out_status]++;
      if (expected_outcomes.size() == 0) begin
        $error("result word arrived with nothing expected");
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("result_id", want.result_id, out_result_id);
        check_field("previous_id", want.previous_id, out_previous_id);
        check_field("stack_address", want.stack_address, out_stack_address);
        check_field("slice_expired", 64'(want.slice_expired), 64'(out_slice_expired));
        check_field("slots_in_use", 64'(want.slots_in_use), 64'(out_slots_in_use));
      end
    end
  end

  // Ends the run when no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $error("no word moved for %0d cycles", HANG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_valid   <= 1'b0;
    in_cmd     <= CMD_TICK;
    in_task_id <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_TIME_SLICE;
    cfg_wdata  <= '0;
    test_reset_defaults();
    test_create_free_switch();
    test_slice_settings();
    test_pool_exhaustion();
    test_random_traffic(400, 30, 25, 25);
    reprogram(16'($urandom_range(1, 8)), $urandom(), 21'($urandom_range(0, 1048576)));
    no_idle = 1'b1;
    test_random_traffic(250, 35, 20, 25);
    no_idle = 1'b0;
    reprogram(16'd2, 32'd0, 21'd0);
    test_random_traffic(400, 50, 15, 15);
    reprogram(16'($urandom_range(0, 4)), $urandom(), 21'($urandom_range(0, 1048576)));
    test_random_traffic(400, 15, 45, 20);
    reprogram(16'hFFFF, 32'hFFFF_FFFF, 21'd1048576);
    test_random_traffic(150, 30, 25, 25);
    stop_sending();
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $error("%0d results never arrived", expected_outcomes.size());
      error_count++;
    end
    $display("Sent %0d creates, %0d frees, %0d ticks, %0d switches; pool full %0d times.",
             cmd_count[CMD_CREATE], cmd_count[CMD_FREE], cmd_count[CMD_TICK],
             cmd_count[CMD_SCHEDULE], pool_full_hits);
    $display("Results: %0d done, %0d refused, %0d bad frees; ready queue overflowed %0d times.",
             status_count[STATUS_DONE], status_count[STATUS_REFUSED],
             status_count[STATUS_BAD_FREE], ring_drops);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
